// ----- rtl/fskvt_pkg.sv -----
// Shared types and constants for the fixed-slot key/value table.
`timescale 1ns / 1ps
`default_nettype none

package fskvt_pkg;

    // Width of the key_length, value_length and read_length fields
    localparam int LEN_W = 4;

    typedef enum logic [2:0] {
        ACT_SET   = 3'd0,
        ACT_GET   = 3'd1,
        ACT_DEL   = 3'd2,
        ACT_MOD   = 3'd3,
        ACT_EXIST = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_PRESENT   = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RES  = 1'b1
    } state_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic    cmp;
        logic    commit;
        logic    any_hit;
        action_t act;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/fskvt_if.sv -----
// Request and response channel interfaces of the key/value table.
`timescale 1ns / 1ps
`default_nettype none

interface fskvt_req_if #(
    parameter int KEY_W = 64,
    parameter int VAL_W = 64
);
    import fskvt_pkg::*;

    logic             valid;
    logic             ready;
    logic [2:0]       action;
    logic [KEY_W-1:0] key_bytes;
    logic [LEN_W-1:0] key_length;
    logic [VAL_W-1:0] value_bytes;
    logic [LEN_W-1:0] value_length;

    modport source (
        output valid, action, key_bytes, key_length, value_bytes, value_length,
        input  ready
    );

    modport sink (
        input  valid, action, key_bytes, key_length, value_bytes, value_length,
        output ready
    );
endinterface

interface fskvt_rsp_if #(
    parameter int VAL_W = 64,
    parameter int CNT_W = 7
);
    import fskvt_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [VAL_W-1:0] read_bytes;
    logic [LEN_W-1:0] read_length;
    logic [CNT_W-1:0] entry_count;

    modport source (
        output valid, status, read_bytes, read_length, entry_count,
        input  ready
    );

    modport sink (
        input  valid, status, read_bytes, read_length, entry_count,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/fskvt_cell.sv -----
// One table slot: stores an entry, compares it and shifts toward the low end on delete.
`timescale 1ns / 1ps
`default_nettype none

module fskvt_cell
    import fskvt_pkg::*;
#(
    parameter int KEY_W  = 64,
    parameter int VAL_W  = 64,
    parameter int KLEN_W = 4,
    parameter int VLEN_W = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctl_t         ctl,
    // compare operand, taken with the request beat
    input  wire logic [KEY_W-1:0]  cmp_key,
    input  wire logic [KLEN_W-1:0] cmp_klen,
    // write operand, held for the commit cycle
    input  wire logic [KEY_W-1:0]  wr_key,
    input  wire logic [KLEN_W-1:0] wr_klen,
    input  wire logic [VAL_W-1:0]  wr_val,
    input  wire logic [VLEN_W-1:0] wr_vlen,
    // chain from the lower neighbor
    input  wire logic              prev_used,
    input  wire logic              hit_below_in,
    output logic                   hit_below_out,
    // contents of the upper neighbor, shifted in on delete
    input  wire logic              up_used,
    input  wire logic [KEY_W-1:0]  up_key,
    input  wire logic [KLEN_W-1:0] up_klen,
    input  wire logic [VAL_W-1:0]  up_val,
    input  wire logic [VLEN_W-1:0] up_vlen,
    // own contents, seen by the lower neighbor
    output logic                   used,
    output logic [KEY_W-1:0]       key,
    output logic [KLEN_W-1:0]      klen,
    output logic [VAL_W-1:0]       val,
    output logic [VLEN_W-1:0]      vlen,
    // value gated by the hit flag for the read reduction
    output logic [VAL_W-1:0]       rd_val,
    output logic [VLEN_W-1:0]      rd_vlen
);

    logic              used_reg, used_next;
    logic              hit_reg, hit_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KLEN_W-1:0] klen_reg, klen_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [VLEN_W-1:0] vlen_reg, vlen_next;

    logic match;
    logic first_free;
    logic shift;

    // Match only a used slot with equal length and bytes
    assign match      = used_reg && (klen_reg == cmp_klen) && (key_reg == cmp_key);
    // Used slots form a solid run from the bottom; the first free one takes a set
    assign first_free = !used_reg && prev_used;
    // Every cell at or above the deleted one takes its upper neighbor
    assign shift      = hit_below_in | hit_reg;

    always_comb
    begin
        hit_next  = ctl.cmp ? match : hit_reg;
        used_next = used_reg;
        key_next  = key_reg;
        klen_next = klen_reg;
        val_next  = val_reg;
        vlen_next = vlen_reg;
        if (ctl.commit)
        begin
            case (ctl.act)
                ACT_SET:
                begin
                    if (!ctl.any_hit && first_free)
                    begin
                        used_next = 1'b1;
                        key_next  = wr_key;
                        klen_next = wr_klen;
                        val_next  = wr_val;
                        vlen_next = wr_vlen;
                    end
                end
                ACT_MOD:
                begin
                    if (hit_reg)
                    begin
                        val_next  = wr_val;
                        vlen_next = wr_vlen;
                    end
                end
                ACT_DEL:
                begin
                    if (shift)
                    begin
                        used_next = up_used;
                        key_next  = up_key;
                        klen_next = up_klen;
                        val_next  = up_val;
                        vlen_next = up_vlen;
                    end
                end
                default:
                begin
                    used_next = used_reg;
                end
            endcase
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            hit_reg  <= hit_next;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        klen_reg <= klen_next;
        val_reg  <= val_next;
        vlen_reg <= vlen_next;
    end

    assign hit_below_out = shift;
    assign used          = used_reg;
    assign key           = key_reg;
    assign klen          = klen_reg;
    assign val           = val_reg;
    assign vlen          = vlen_reg;
    assign rd_val        = hit_reg ? val_reg : '0;
    assign rd_vlen       = hit_reg ? vlen_reg : '0;

endmodule

`default_nettype wire

// ----- rtl/fixed_slot_key_value_table_core.sv -----
// Top level of the fixed-slot key/value table: request sequencer and row of slot cells.
//
// Usage:
//   req carries one request per beat: action, key bytes and length, and for
//   set and modify a value and its length. Lengths above the byte widths are
//   saturated and bytes above the length are dropped.
//   rsp returns exactly one beat per request: status, the stored value on a
//   successful get, and the number of live entries after the request.
// Timing:
//   All cells compare the key in the cycle the request beat is taken; the
//   commit step that follows changes the cells and loads the response
//   register, once that register is free. The response is registered, and
//   a request occupies the block through its compare and commit steps over
//   the cell row. req is ready again as soon as the response is loaded.
// Stalls:
//   When rsp is held off, the response register keeps its beat; a following
//   request is still compared and then waits in the commit step until the
//   register frees up.
// Reset:
//   Clears the used flag of every cell and the live count at once; the
//   table is empty and ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module fixed_slot_key_value_table_core
    import fskvt_pkg::*;
#(
    parameter int SLOTS       = 64,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BYTES = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fskvt_req_if.sink   req,
    fskvt_rsp_if.source rsp
);

    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int VAL_W  = 8 * VALUE_BYTES;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int KLEN_W = $clog2(KEY_BYTES + 1);
    localparam int VLEN_W = $clog2(VALUE_BYTES + 1);

    state_t state_reg, state_next;

    // Held request for the commit cycle
    action_t           act_reg, act_next;
    logic [KEY_W-1:0]  wkey_reg, wkey_next;
    logic [KLEN_W-1:0] wklen_reg, wklen_next;
    logic [VAL_W-1:0]  wval_reg, wval_next;
    logic [VLEN_W-1:0] wvlen_reg, wvlen_next;

    logic [CNT_W-1:0]  count_reg, count_next;

    // Response register
    logic              rsp_valid_reg, rsp_valid_next;
    status_t           status_reg, status_next;
    logic [VAL_W-1:0]  rbytes_reg, rbytes_next;
    logic [VLEN_W-1:0] rlen_reg, rlen_next;

    // Normalized request operands
    logic [LEN_W-1:0]  klen_sat, vlen_sat;
    logic [KEY_W-1:0]  kmask;
    logic [VAL_W-1:0]  vmask;
    logic [KEY_W-1:0]  in_key;
    logic [KLEN_W-1:0] in_klen;
    logic [VAL_W-1:0]  in_val;
    logic [VLEN_W-1:0] in_vlen;

    logic      accept;
    logic      commit;
    logic      any_hit;
    logic      full;
    cell_ctl_t ctl;

    // Cell row wiring; index SLOTS is the empty slot above the top cell
    logic              c_used [SLOTS+1];
    logic [KEY_W-1:0]  c_key  [SLOTS+1];
    logic [KLEN_W-1:0] c_klen [SLOTS+1];
    logic [VAL_W-1:0]  c_val  [SLOTS+1];
    logic [VLEN_W-1:0] c_vlen [SLOTS+1];
    logic              c_hb   [SLOTS+1];
    logic [VAL_W-1:0]  c_rdv  [SLOTS];
    logic [VLEN_W-1:0] c_rdl  [SLOTS];
    logic [VAL_W-1:0]  rd_val_all;
    logic [VLEN_W-1:0] rd_len_all;

    // Saturate lengths and drop bytes above them
    always_comb
    begin
        klen_sat = (req.key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : req.key_length;
        vlen_sat = (req.value_length > LEN_W'(VALUE_BYTES)) ? LEN_W'(VALUE_BYTES)
                                                            : req.value_length;
        for (int b = 0; b < KEY_W; b++)
        begin
            kmask[b] = (LEN_W'(b / 8) < klen_sat);
        end
        for (int b = 0; b < VAL_W; b++)
        begin
            vmask[b] = (LEN_W'(b / 8) < vlen_sat);
        end
        in_key  = req.key_bytes & kmask;
        in_val  = req.value_bytes & vmask;
        in_klen = klen_sat[KLEN_W-1:0];
        in_vlen = vlen_sat[VLEN_W-1:0];
    end

    // Build the row of slots
    assign c_used[SLOTS] = 1'b0;
    assign c_key[SLOTS]  = '0;
    assign c_klen[SLOTS] = '0;
    assign c_val[SLOTS]  = '0;
    assign c_vlen[SLOTS] = '0;
    assign c_hb[0]       = 1'b0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic prev_used;

        if (i == 0)
        begin : g_first
            assign prev_used = 1'b1;
        end
        else
        begin : g_rest
            assign prev_used = c_used[i-1];
        end

        fskvt_cell #(
            .KEY_W  (KEY_W),
            .VAL_W  (VAL_W),
            .KLEN_W (KLEN_W),
            .VLEN_W (VLEN_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .cmp_key       (in_key),
            .cmp_klen      (in_klen),
            .wr_key        (wkey_reg),
            .wr_klen       (wklen_reg),
            .wr_val        (wval_reg),
            .wr_vlen       (wvlen_reg),
            .prev_used     (prev_used),
            .hit_below_in  (c_hb[i]),
            .hit_below_out (c_hb[i+1]),
            .up_used       (c_used[i+1]),
            .up_key        (c_key[i+1]),
            .up_klen       (c_klen[i+1]),
            .up_val        (c_val[i+1]),
            .up_vlen       (c_vlen[i+1]),
            .used          (c_used[i]),
            .key           (c_key[i]),
            .klen          (c_klen[i]),
            .val           (c_val[i]),
            .vlen          (c_vlen[i]),
            .rd_val        (c_rdv[i]),
            .rd_vlen       (c_rdl[i])
        );
    end

    // Keys are unique, so at most one cell drives a nonzero read value
    always_comb
    begin
        rd_val_all = '0;
        rd_len_all = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            rd_val_all = rd_val_all | c_rdv[i];
            rd_len_all = rd_len_all | c_rdl[i];
        end
    end

    assign any_hit = c_hb[SLOTS];
    assign full    = c_used[SLOTS-1];

    // Sequencer: next state, cell control and response
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        wkey_next      = wkey_reg;
        wklen_next     = wklen_reg;
        wval_next      = wval_reg;
        wvlen_next     = wvlen_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        rbytes_next    = rbytes_reg;
        rlen_next      = rlen_reg;
        accept         = 1'b0;
        commit         = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                accept = req.valid;
                if (req.valid)
                begin
                    act_next   = action_t'(req.action);
                    wkey_next  = in_key;
                    wklen_next = in_klen;
                    wval_next  = in_val;
                    wvlen_next = in_vlen;
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    commit         = 1'b1;
                    rsp_valid_next = 1'b1;
                    rbytes_next    = '0;
                    rlen_next      = '0;
                    status_next    = ST_OK;
                    state_next     = S_IDLE;
                    case (act_reg)
                        ACT_SET:
                        begin
                            if (any_hit)
                            begin
                                status_next = ST_PRESENT;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_GET:
                        begin
                            if (any_hit)
                            begin
                                rbytes_next = rd_val_all;
                                rlen_next   = rd_len_all;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        ACT_DEL:
                        begin
                            if (any_hit)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        ACT_MOD, ACT_EXIST:
                        begin
                            status_next = any_hit ? ST_OK : ST_NOT_FOUND;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ctl.cmp     = accept;
    assign ctl.commit  = commit;
    assign ctl.any_hit = any_hit;
    assign ctl.act     = act_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Held request and response payload
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        wkey_reg   <= wkey_next;
        wklen_reg  <= wklen_next;
        wval_reg   <= wval_next;
        wvlen_reg  <= wvlen_next;
        status_reg <= status_next;
        rbytes_reg <= rbytes_next;
        rlen_reg   <= rlen_next;
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.read_bytes  = rbytes_reg;
    assign rsp.read_length = LEN_W'(rlen_reg);
    assign rsp.entry_count = count_reg;

endmodule

`default_nettype wire

// ----- rtl/fskvt_checker.sv -----
// Port-level checks of the key/value table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fskvt_checker
    import fskvt_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int CNT_W = 7
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic [1:0]       status,
    input wire logic [LEN_W-1:0] read_length,
    input wire logic [CNT_W-1:0] entry_count
);

    // Hold a stalled response beat
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_count))
    else $error("stalled response beat changed");

    // Take one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is still at work");

    // Return read data only with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (read_length != '0) |-> (status == ST_OK))
    else $error("read length on a failed request");

    // Report full only when every slot is live
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL) |-> (entry_count == CNT_W'(SLOTS)))
    else $error("table full reported below capacity");

    // Never count past the slot total
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= CNT_W'(SLOTS))
    else $error("entry count above slot total");

endmodule

bind fixed_slot_key_value_table_core fskvt_checker #(
    .SLOTS (SLOTS),
    .CNT_W (CNT_W)
) u_fskvt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .read_length (rsp.read_length),
    .entry_count (rsp.entry_count)
);

`default_nettype wire
